### design/tkvt_pkg.sv
// Shared types and constants for the top-k value tracker.
// Used by the tracker cell and the top level; depends on nothing else.
package tkvt_pkg;

  localparam int K_MAX   = 16;
  localparam int VALUE_W = 31;
  localparam int LIMIT_W = 5;
  localparam int FILL_W  = $clog2(K_MAX + 1);
  localparam int CMP_W   = (LIMIT_W > FILL_W) ? LIMIT_W : FILL_W;
  localparam int DATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_W   = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic               ins;
    logic               full;
    logic [VALUE_W-1:0] value;
  } bcast_t;

  // Handed from each cell to its right neighbor.
  typedef struct packed {
    logic               valid;
    logic               take;
    logic [VALUE_W-1:0] value;
  } link_t;

endpackage

### design/tkvt_cell.sv
// One slot of the sorted value chain (largest value in the leftmost cell).
// Depends on tkvt_pkg for the broadcast and link structs.
module tkvt_cell (
  input  logic           clk,
  input  logic           rst,
  input  tkvt_pkg::bcast_t bc,
  input  tkvt_pkg::link_t  prev,
  output tkvt_pkg::link_t  link,
  output logic           hit
);
  import tkvt_pkg::*;

  logic               valid;
  logic [VALUE_W-1:0] value;
  logic               take;
  logic               upd;

  // The new value belongs at or left of this cell unless this cell holds
  // something at least as large. Ordering keeps take monotone along the chain.
  assign take = !(valid && (value >= bc.value));
  assign hit  = valid && (value == bc.value);
  assign link = '{valid: valid, take: take, value: value};

  // In a full store only held cells move, so the minimum at the tail drops out.
  assign upd = bc.ins && take && (!bc.full || valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd) begin
      valid <= prev.take ? prev.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      value <= prev.take ? prev.value : bc.value;
    end
  end

endmodule

### design/top_k_value_tracker_top.sv
// Top-k value tracker: a chain of cells kept sorted, largest value first.
// A query result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while the output register is empty or being read; each
// cell compares against the request in parallel and shifts into its neighbor in the same cycle.
// Reset: the store is empty, the output register is empty, and the limit is 16.
// Depends on tkvt_pkg and tkvt_cell.
module top_k_value_tracker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tkvt_pkg::LIMIT_W-1:0]  cfg_wdata,   // slot_limit
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tkvt_pkg::DATA_W-1:0]   s_tdata,     // value, then zero fill
  input  logic                          s_tuser,     // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tkvt_pkg::OUT_W-1:0]    m_tdata      // present, then zero fill
);
  import tkvt_pkg::*;

  logic [LIMIT_W-1:0] slot_limit;
  logic [FILL_W-1:0]  fill_count;
  logic [CMP_W-1:0]   limit_wide;
  logic [FILL_W-1:0]  eff_limit;
  logic               full;
  logic               accept;
  logic               is_query;
  logic               present;
  logic [K_MAX-1:0]   hits;
  bcast_t             bc;
  link_t              links [K_MAX+1];

  // A limit of zero acts as one; a limit above the cell count acts as the count.
  always_comb begin
    limit_wide = CMP_W'(slot_limit);
    if (slot_limit == '0) begin
      limit_wide = CMP_W'(1);
    end else if (CMP_W'(slot_limit) > CMP_W'(K_MAX)) begin
      limit_wide = CMP_W'(K_MAX);
    end
  end

  assign eff_limit = limit_wide[FILL_W-1:0];
  assign full      = fill_count >= eff_limit;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_query  = (cmd_t'(s_tuser) == CMD_QUERY);
  assign bc        = '{ins: accept && !is_query, full: full, value: s_tdata[VALUE_W-1:0]};
  assign links[0]  = '{valid: 1'b0, take: 1'b0, value: '0};
  assign m_tdata   = OUT_W'(present);

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    tkvt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .bc   (bc),
      .prev (links[i]),
      .link (links[i+1]),
      .hit  (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      slot_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (bc.ins && !full) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (accept && is_query) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      present <= |hits;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(K_MAX))
    else $error("fill count beyond cell count");

  a_tail_valid: assert property (@(posedge clk) disable iff (rst)
    links[K_MAX].valid == (fill_count == FILL_W'(K_MAX)))
    else $error("last cell valid bit disagrees with fill count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (bc.ins && !full) |=> (fill_count == $past(fill_count) + FILL_W'(1)))
    else $error("insert into a store with room did not grow it");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_query) |=> m_tvalid)
    else $error("query request produced no result");

  a_full_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    (bc.ins && full) |=> $stable(fill_count))
    else $error("insert into a full store changed the fill count");
`endif

endmodule
